FILE: src/video_sync_timing_generator_assert.svh
// Assertion macros for the video sync timing generator checker
`ifndef VIDEO_SYNC_TIMING_GENERATOR_ASSERT_SVH
`define VIDEO_SYNC_TIMING_GENERATOR_ASSERT_SVH

// clocked assertion, disabled while reset is high
`define VSTG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define VSTG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/vstg_pkg.sv
// Types, register indexes and reset values for the video sync timing generator
package vstg_pkg;

   localparam int CNT_W   = 11;
   localparam int PORCH_W = 8;
   localparam int FRAME_W = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 11;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_H_VISIBLE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_H_FRONT   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_H_SYNC    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_H_BACK    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_V_VISIBLE = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_V_FRONT   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_V_SYNC    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_V_BACK    = 4'd7;

   // register reset values
   localparam logic [CNT_W-1:0]   RST_H_VISIBLE = 11'd640;
   localparam logic [PORCH_W-1:0] RST_H_FRONT   = 8'd16;
   localparam logic [PORCH_W-1:0] RST_H_SYNC    = 8'd96;
   localparam logic [PORCH_W-1:0] RST_H_BACK    = 8'd48;
   localparam logic [CNT_W-1:0]   RST_V_VISIBLE = 11'd480;
   localparam logic [PORCH_W-1:0] RST_V_FRONT   = 8'd10;
   localparam logic [PORCH_W-1:0] RST_V_SYNC    = 8'd2;
   localparam logic [PORCH_W-1:0] RST_V_BACK    = 8'd33;

   typedef enum logic [3:0] {
      H_FRONT   = 4'b0001,
      H_SYNC    = 4'b0010,
      H_BACK    = 4'b0100,
      H_VISIBLE = 4'b1000
   } h_phase_type;

   typedef enum logic [3:0] {
      V_VISIBLE = 4'b0001,
      V_FRONT   = 4'b0010,
      V_SYNC    = 4'b0100,
      V_BACK    = 4'b1000
   } v_phase_type;

   typedef struct packed {
      logic [CNT_W-1:0]   h_visible;
      logic [PORCH_W-1:0] h_fporch;
      logic [PORCH_W-1:0] h_sync_width;
      logic [PORCH_W-1:0] h_bporch;
      logic [CNT_W-1:0]   v_visible;
      logic [PORCH_W-1:0] v_fporch;
      logic [PORCH_W-1:0] v_sync_lines;
      logic [PORCH_W-1:0] v_bporch;
   } cfg_type;

   typedef struct packed {
      logic               hsync;
      logic               vsync;
      logic               data_enable;
      logic               vblank;
      logic [FRAME_W-1:0] frame_number;
   } rsp_type;

endpackage

FILE: src/vstg_csr.sv
// Timing configuration registers with write port
module vstg_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [vstg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vstg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output vstg_pkg::cfg_type                cfg
);

   vstg_pkg::cfg_type cfg_ff;
   vstg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            vstg_pkg::CSR_H_VISIBLE: cfg_in.h_visible = csr_wdata;
            vstg_pkg::CSR_H_FRONT:   cfg_in.h_fporch = csr_wdata[vstg_pkg::PORCH_W-1:0];
            vstg_pkg::CSR_H_SYNC:    cfg_in.h_sync_width = csr_wdata[vstg_pkg::PORCH_W-1:0];
            vstg_pkg::CSR_H_BACK:    cfg_in.h_bporch = csr_wdata[vstg_pkg::PORCH_W-1:0];
            vstg_pkg::CSR_V_VISIBLE: cfg_in.v_visible = csr_wdata;
            vstg_pkg::CSR_V_FRONT:   cfg_in.v_fporch = csr_wdata[vstg_pkg::PORCH_W-1:0];
            vstg_pkg::CSR_V_SYNC:    cfg_in.v_sync_lines = csr_wdata[vstg_pkg::PORCH_W-1:0];
            vstg_pkg::CSR_V_BACK:    cfg_in.v_bporch = csr_wdata[vstg_pkg::PORCH_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.h_visible    <= vstg_pkg::RST_H_VISIBLE;
         cfg_ff.h_fporch     <= vstg_pkg::RST_H_FRONT;
         cfg_ff.h_sync_width <= vstg_pkg::RST_H_SYNC;
         cfg_ff.h_bporch     <= vstg_pkg::RST_H_BACK;
         cfg_ff.v_visible    <= vstg_pkg::RST_V_VISIBLE;
         cfg_ff.v_fporch     <= vstg_pkg::RST_V_FRONT;
         cfg_ff.v_sync_lines <= vstg_pkg::RST_V_SYNC;
         cfg_ff.v_bporch     <= vstg_pkg::RST_V_BACK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/vstg_timing.sv
// Horizontal and vertical phase counters, frame counter and sync decode
module vstg_timing (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              pixel_tick,
   input  vstg_pkg::cfg_type cfg,
   output vstg_pkg::rsp_type rsp
);

   vstg_pkg::h_phase_type h_phase_ff, h_phase_in, h_phase_next;
   vstg_pkg::v_phase_type v_phase_ff, v_phase_in, v_phase_next;
   logic [vstg_pkg::CNT_W-1:0]   h_count_ff, h_count_in;
   logic [vstg_pkg::CNT_W-1:0]   v_count_ff, v_count_in;
   logic                         vblank_ff, vblank_in;
   logic [vstg_pkg::FRAME_W-1:0] frame_ff, frame_in;

   logic [vstg_pkg::CNT_W-1:0] h_len, h_len_eff, h_next;
   logic [vstg_pkg::CNT_W-1:0] v_len, v_len_eff, v_next;
   logic                       h_done, v_done;

   always_comb begin
      unique case (h_phase_ff)
         vstg_pkg::H_FRONT: begin
            h_len = {3'b000, cfg.h_fporch};
            h_phase_next = vstg_pkg::H_SYNC;
         end
         vstg_pkg::H_SYNC: begin
            h_len = {3'b000, cfg.h_sync_width};
            h_phase_next = vstg_pkg::H_BACK;
         end
         vstg_pkg::H_BACK: begin
            h_len = {3'b000, cfg.h_bporch};
            h_phase_next = vstg_pkg::H_VISIBLE;
         end
         default: begin
            h_len = cfg.h_visible;
            h_phase_next = vstg_pkg::H_FRONT;
         end
      endcase
   end

   always_comb begin
      unique case (v_phase_ff)
         vstg_pkg::V_FRONT: begin
            v_len = {3'b000, cfg.v_fporch};
            v_phase_next = vstg_pkg::V_SYNC;
         end
         vstg_pkg::V_SYNC: begin
            v_len = {3'b000, cfg.v_sync_lines};
            v_phase_next = vstg_pkg::V_BACK;
         end
         vstg_pkg::V_BACK: begin
            v_len = {3'b000, cfg.v_bporch};
            v_phase_next = vstg_pkg::V_VISIBLE;
         end
         default: begin
            v_len = cfg.v_visible;
            v_phase_next = vstg_pkg::V_FRONT;
         end
      endcase
   end

   // a zero length register counts as one
   assign h_len_eff = (h_len == '0) ? 11'd1 : h_len;
   assign v_len_eff = (v_len == '0) ? 11'd1 : v_len;
   assign h_next    = h_count_ff + 11'd1;
   assign v_next    = v_count_ff + 11'd1;
   assign h_done    = (h_next >= h_len_eff);
   assign v_done    = (v_next >= v_len_eff);

   always_comb begin
      h_phase_in = h_phase_ff;
      h_count_in = h_count_ff;
      v_phase_in = v_phase_ff;
      v_count_in = v_count_ff;
      vblank_in  = vblank_ff;
      frame_in   = frame_ff;
      if (advance && pixel_tick) begin
         if (h_done) begin
            h_count_in = '0;
            h_phase_in = h_phase_next;
            if (h_phase_ff == vstg_pkg::H_VISIBLE) begin
               // end of scanline steps the vertical counter
               if (v_done) begin
                  v_count_in = '0;
                  v_phase_in = v_phase_next;
                  if (v_phase_next == vstg_pkg::V_FRONT) begin
                     vblank_in = 1'b1;
                     frame_in  = frame_ff + 32'd1;
                  end else if (v_phase_next == vstg_pkg::V_VISIBLE) begin
                     vblank_in = 1'b0;
                  end
               end else begin
                  v_count_in = v_next;
               end
            end
         end else begin
            h_count_in = h_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_phase_ff <= vstg_pkg::H_FRONT;
         h_count_ff <= '0;
         v_phase_ff <= vstg_pkg::V_VISIBLE;
         v_count_ff <= '0;
         vblank_ff  <= 1'b0;
         frame_ff   <= '0;
      end else begin
         h_phase_ff <= h_phase_in;
         h_count_ff <= h_count_in;
         v_phase_ff <= v_phase_in;
         v_count_ff <= v_count_in;
         vblank_ff  <= vblank_in;
         frame_ff   <= frame_in;
      end
   end

   // result describes the pixel before the counters advance
   assign rsp.hsync        = (h_phase_ff == vstg_pkg::H_SYNC);
   assign rsp.vsync        = (v_phase_ff == vstg_pkg::V_SYNC);
   assign rsp.data_enable  = (h_phase_ff == vstg_pkg::H_VISIBLE) &&
                             (v_phase_ff == vstg_pkg::V_VISIBLE);
   assign rsp.vblank       = vblank_ff;
   assign rsp.frame_number = frame_ff;

endmodule

FILE: src/vstg_out_buf.sv
// Result register with skid stage between the timing logic and the rsp channel
module vstg_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  vstg_pkg::rsp_type in_data,
   output logic              in_stall,
   output logic              out_valid,
   input  logic              out_stall,
   output vstg_pkg::rsp_type out_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   vstg_pkg::rsp_type out_data_ff, out_data_in;
   vstg_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              out_free;

   assign out_free = !out_valid_ff || !out_stall;
   assign in_stall = skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (out_free) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

FILE: src/video_sync_timing_generator.sv
// Display sync timing generator top level
//
// req channel: one transaction per pixel; req_pixel_tick set advances the
// horizontal and vertical counters by one pixel, clear holds them.
// rsp channel: exactly one transaction per req transaction, in order, giving
// hsync, vsync, data_enable, vblank and frame_number of the pixel the
// counters pointed at when the req transaction was taken.
// csr port: eight timing registers (index 0..7, pixels then lines), to be
// written while the block is idle, which the block itself does not enforce;
// other indexes are ignored. A taken req transaction goes to the result
// register, or to the skid stage while a result is held. Throughput: one
// transaction per cycle unless stalled; the phase decode sits between the counter and result registers.
// Reset: counters go to the start of the horizontal front porch on the first
// active line, frame 0, registers to 640x480 timing; rsp_valid drops.
// Stall: a result held by rsp_stall stays in the result register; one more
// transaction is taken into the skid stage, then req_stall rises until the
// receiver drains it.
module video_sync_timing_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_pixel_tick,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hsync,
   output logic                                 rsp_vsync,
   output logic                                 rsp_data_enable,
   output logic                                 rsp_vblank,
   output logic [vstg_pkg::FRAME_W-1:0]         rsp_frame_number,
   input  logic                                 csr_wr_en,
   input  logic [vstg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vstg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   vstg_pkg::cfg_type cfg;
   vstg_pkg::rsp_type pix_rsp;
   vstg_pkg::rsp_type out_rsp;
   logic              req_accept;

   assign req_accept = req_valid && !req_stall;

   vstg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vstg_timing u_timing (
      .clock      (clock),
      .reset      (reset),
      .advance    (req_accept),
      .pixel_tick (req_pixel_tick),
      .cfg        (cfg),
      .rsp        (pix_rsp)
   );

   vstg_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (pix_rsp),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_rsp)
   );

   assign rsp_hsync        = out_rsp.hsync;
   assign rsp_vsync        = out_rsp.vsync;
   assign rsp_data_enable  = out_rsp.data_enable;
   assign rsp_vblank       = out_rsp.vblank;
   assign rsp_frame_number = out_rsp.frame_number;

endmodule

FILE: src/vstg_checker.sv
// Port level checker for the video sync timing generator, bound to the top level
`include "video_sync_timing_generator_assert.svh"

module vstg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_hsync,
   input logic                            rsp_vsync,
   input logic                            rsp_data_enable,
   input logic                            rsp_vblank,
   input logic [vstg_pkg::FRAME_W-1:0]    rsp_frame_number
);

   `VSTG_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid && !req_stall), "rsp_valid or req_stall set after reset")
   `VSTG_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_frame_number) && $stable(rsp_hsync) && $stable(rsp_vsync)), "stalled rsp transaction changed")
   `VSTG_ASSERT(a_de_not_blank, clock, reset, (rsp_valid && rsp_data_enable) |-> (!rsp_vblank && !rsp_hsync && !rsp_vsync), "data_enable during blanking or sync")
   `VSTG_ASSERT(a_vsync_in_blank, clock, reset, (rsp_valid && rsp_vsync) |-> rsp_vblank, "vsync outside vblank")
   `VSTG_ASSERT(a_no_stall_empty, clock, reset, (req_stall && !$past(reset)) |-> $past(rsp_valid && rsp_stall), "req_stall without a stalled result")

endmodule

bind video_sync_timing_generator vstg_checker u_vstg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_hsync        (rsp_hsync),
   .rsp_vsync        (rsp_vsync),
   .rsp_data_enable  (rsp_data_enable),
   .rsp_vblank       (rsp_vblank),
   .rsp_frame_number (rsp_frame_number)
);

FILE: bench/tb_video_sync_timing_generator.sv
// Self-checking testbench for the video sync timing generator
`timescale 1ns / 100ps

module tb_video_sync_timing_generator;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int PX_PER_SET  = 100;
   // indexes that decode to no register
   localparam logic [vstg_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = 4'd8;
   localparam logic [vstg_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 4'd15;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_pixel_tick;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_hsync;
   logic                            rsp_vsync;
   logic                            rsp_data_enable;
   logic                            rsp_vblank;
   logic [vstg_pkg::FRAME_W-1:0]    rsp_frame_number;
   logic                            csr_wr_en;
   logic [vstg_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [vstg_pkg::CSR_DATA_W-1:0] csr_wdata;

   // predictor state
   vstg_pkg::cfg_type               timing;
   vstg_pkg::h_phase_type           pix_phase;
   logic [vstg_pkg::CNT_W-1:0]      pix_count;
   vstg_pkg::v_phase_type           line_phase;
   logic [vstg_pkg::CNT_W-1:0]      line_count;
   logic                            vblank_now;
   logic [vstg_pkg::FRAME_W-1:0]    frame_count;
   vstg_pkg::rsp_type               expected_px[$];

   vstg_pkg::rsp_type               want_px;
   vstg_pkg::rsp_type               seen_px;
   int                              fail_count;
   int unsigned                     send_idle_pct;
   int unsigned                     recv_idle_pct;
   int unsigned                     hold_len;
   int unsigned                     hold_seq;

   video_sync_timing_generator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_tick   (req_pixel_tick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hsync        (rsp_hsync),
      .rsp_vsync        (rsp_vsync),
      .rsp_data_enable  (rsp_data_enable),
      .rsp_vblank       (rsp_vblank),
      .rsp_frame_number (rsp_frame_number),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // a zero register still lasts one pixel or line
   function automatic logic [vstg_pkg::CNT_W:0] span_of(input logic [vstg_pkg::CNT_W-1:0] len);
      return (len == '0) ? {{vstg_pkg::CNT_W{1'b0}}, 1'b1} : {1'b0, len};
   endfunction

   function automatic logic [vstg_pkg::CSR_DATA_W-1:0] rand_upto(input int unsigned hi);
      logic [31:0] r;
      r = $urandom_range(hi);
      return r[vstg_pkg::CSR_DATA_W-1:0];
   endfunction

   function automatic logic [vstg_pkg::CSR_IDX_W-1:0] rand_dead_index();
      logic [31:0] r;
      r = $urandom_range(CSR_UNUSED_HI, CSR_UNUSED_LO);
      return r[vstg_pkg::CSR_IDX_W-1:0];
   endfunction

   // pixel the counters point at, then advance them
   function automatic vstg_pkg::rsp_type predict_pixel(input logic tick);
      vstg_pkg::rsp_type          px;
      logic [vstg_pkg::CNT_W-1:0] nxt;
      logic [vstg_pkg::CNT_W:0]   len;
      px.hsync        = (pix_phase == vstg_pkg::H_SYNC);
      px.vsync        = (line_phase == vstg_pkg::V_SYNC);
      px.data_enable  = (pix_phase == vstg_pkg::H_VISIBLE) &&
                        (line_phase == vstg_pkg::V_VISIBLE);
      px.vblank       = vblank_now;
      px.frame_number = frame_count;
      if (tick) begin
         case (pix_phase)
            vstg_pkg::H_FRONT: len = span_of(timing.h_fporch);
            vstg_pkg::H_SYNC:  len = span_of(timing.h_sync_width);
            vstg_pkg::H_BACK:  len = span_of(timing.h_bporch);
            default:           len = span_of(timing.h_visible);
         endcase
         nxt = pix_count + 1'b1;
         if (nxt >= len) begin
            pix_count = '0;
            case (pix_phase)
               vstg_pkg::H_FRONT: pix_phase = vstg_pkg::H_SYNC;
               vstg_pkg::H_SYNC:  pix_phase = vstg_pkg::H_BACK;
               vstg_pkg::H_BACK:  pix_phase = vstg_pkg::H_VISIBLE;
               default: begin
                  pix_phase = vstg_pkg::H_FRONT;
                  // end of scanline
                  case (line_phase)
                     vstg_pkg::V_VISIBLE: len = span_of(timing.v_visible);
                     vstg_pkg::V_FRONT:   len = span_of(timing.v_fporch);
                     vstg_pkg::V_SYNC:    len = span_of(timing.v_sync_lines);
                     default:             len = span_of(timing.v_bporch);
                  endcase
                  nxt = line_count + 1'b1;
                  if (nxt >= len) begin
                     line_count = '0;
                     case (line_phase)
                        vstg_pkg::V_VISIBLE: begin
                           line_phase  = vstg_pkg::V_FRONT;
                           vblank_now  = 1'b1;
                           frame_count = frame_count + 1'b1;
                        end
                        vstg_pkg::V_FRONT: line_phase = vstg_pkg::V_SYNC;
                        vstg_pkg::V_SYNC:  line_phase = vstg_pkg::V_BACK;
                        default: begin
                           line_phase = vstg_pkg::V_VISIBLE;
                           vblank_now = 1'b0;
                        end
                     endcase
                  end else begin
                     line_count = nxt;
                  end
               end
            endcase
         end else begin
            pix_count = nxt;
         end
      end
      return px;
   endfunction

   function automatic void report_mismatch(input string what, input vstg_pkg::rsp_type want,
                                           input vstg_pkg::rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%s: expected hs=%0b vs=%0b de=%0b vb=%0b frame=%0d, got hs=%0b vs=%0b de=%0b vb=%0b frame=%0d",
                  what, want.hsync, want.vsync, want.data_enable, want.vblank,
                  want.frame_number, got.hsync, got.vsync, got.data_enable,
                  got.vblank, got.frame_number);
   endfunction

   // one pixel transaction; prediction happens on acceptance
   task automatic send_pixel(input logic tick);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_tick <= tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_px.push_back(predict_pixel(tick));
   endtask

   task automatic send_pixels(input int count);
      repeat (count) send_pixel($urandom_range(99) < 85);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [vstg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [vstg_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         vstg_pkg::CSR_H_VISIBLE: timing.h_visible    = data;
         vstg_pkg::CSR_H_FRONT:   timing.h_fporch     = data[vstg_pkg::PORCH_W-1:0];
         vstg_pkg::CSR_H_SYNC:    timing.h_sync_width = data[vstg_pkg::PORCH_W-1:0];
         vstg_pkg::CSR_H_BACK:    timing.h_bporch     = data[vstg_pkg::PORCH_W-1:0];
         vstg_pkg::CSR_V_VISIBLE: timing.v_visible    = data;
         vstg_pkg::CSR_V_FRONT:   timing.v_fporch     = data[vstg_pkg::PORCH_W-1:0];
         vstg_pkg::CSR_V_SYNC:    timing.v_sync_lines = data[vstg_pkg::PORCH_W-1:0];
         vstg_pkg::CSR_V_BACK:    timing.v_bporch     = data[vstg_pkg::PORCH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_timing(input logic [vstg_pkg::CSR_DATA_W-1:0] h_act, h_fp, h_sw, h_bp,
                               input logic [vstg_pkg::CSR_DATA_W-1:0] v_act, v_fp, v_sl, v_bp);
      write_reg(vstg_pkg::CSR_H_VISIBLE, h_act);
      write_reg(vstg_pkg::CSR_H_FRONT, h_fp);
      write_reg(vstg_pkg::CSR_H_SYNC, h_sw);
      write_reg(vstg_pkg::CSR_H_BACK, h_bp);
      write_reg(vstg_pkg::CSR_V_VISIBLE, v_act);
      write_reg(vstg_pkg::CSR_V_FRONT, v_fp);
      write_reg(vstg_pkg::CSR_V_SYNC, v_sl);
      write_reg(vstg_pkg::CSR_V_BACK, v_bp);
   endtask

   // default timing, held pixels, dead indexes, shortening a running phase, zero lengths
   task automatic test_directed_cases();
      send_pixel(1'b0);
      send_pixel(1'b1);
      send_pixel(1'b1);
      send_pixel(1'b1);
      send_pixel(1'b0);
      wait_drained();
      write_reg(CSR_UNUSED_LO, '0);
      write_reg(CSR_UNUSED_HI, '0);
      // front porch already ran 3 pixels, so it ends after the next one
      write_reg(vstg_pkg::CSR_H_FRONT, 11'd2);
      send_pixel(1'b1);
      send_pixel(1'b1);
      wait_drained();
      write_timing('0, '0, '0, '0, '0, '0, '0, '0);
      repeat (17) send_pixel(1'b1);
   endtask

   // lengths of zero to three: frames wrap every few dozen pixels
   task automatic test_small_frames(input int sets);
      repeat (sets) begin
         wait_drained();
         write_timing(rand_upto(3), rand_upto(3), rand_upto(3), rand_upto(3),
                      rand_upto(3), rand_upto(3), rand_upto(3), rand_upto(3));
         send_pixels(PX_PER_SET);
      end
   endtask

   task automatic test_random_timing(input int sets);
      repeat (sets) begin
         wait_drained();
         write_reg(rand_dead_index(), rand_upto(2047));
         write_timing(rand_upto(12), rand_upto(6), rand_upto(6), rand_upto(6),
                      rand_upto(4), rand_upto(3), rand_upto(3), rand_upto(3));
         send_pixels(PX_PER_SET);
      end
   endtask

   // all ones in every register (porches truncate to 255), three-pixel and one-line phases, the reset timing
   task automatic test_extreme_registers();
      wait_drained();
      write_timing('1, '1, '1, '1, '1, '1, '1, '1);
      send_pixels(PX_PER_SET);
      wait_drained();
      write_timing(11'd3, 11'd3, 11'd3, 11'd3, 11'd1, 11'd1, 11'd1, 11'd1);
      send_pixels(PX_PER_SET);
      wait_drained();
      write_timing(vstg_pkg::RST_H_VISIBLE, {3'b000, vstg_pkg::RST_H_FRONT},
                   {3'b000, vstg_pkg::RST_H_SYNC}, {3'b000, vstg_pkg::RST_H_BACK},
                   vstg_pkg::RST_V_VISIBLE, {3'b000, vstg_pkg::RST_V_FRONT},
                   {3'b000, vstg_pkg::RST_V_SYNC}, {3'b000, vstg_pkg::RST_V_BACK});
      send_pixels(PX_PER_SET);
   endtask

   // receiver holds off while pixels keep coming, so the input backs up
   task automatic test_backpressure();
      wait_drained();
      write_timing(rand_upto(3), rand_upto(3), rand_upto(3), rand_upto(3),
                   rand_upto(3), rand_upto(3), rand_upto(3), rand_upto(3));
      @(negedge clock);
      hold_len = HOLD_CYCLES;
      hold_seq++;
      @(posedge clock);
      send_pixels(60);
   endtask

   initial begin : rsp_stall_gen
      int unsigned hold_left;
      int unsigned seen_seq;
      hold_left = 0;
      seen_seq  = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != seen_seq) begin
            seen_seq  = hold_seq;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_px.hsync        = rsp_hsync;
         seen_px.vsync        = rsp_vsync;
         seen_px.data_enable  = rsp_data_enable;
         seen_px.vblank       = rsp_vblank;
         seen_px.frame_number = rsp_frame_number;
         if (expected_px.size() == 0) begin
            report_mismatch("unexpected pixel", '0, seen_px);
         end else begin
            want_px = expected_px.pop_front();
            if (seen_px.hsync !== want_px.hsync || seen_px.vsync !== want_px.vsync ||
                seen_px.data_enable !== want_px.data_enable ||
                seen_px.vblank !== want_px.vblank ||
                seen_px.frame_number !== want_px.frame_number)
               report_mismatch("pixel mismatch", want_px, seen_px);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("video_sync_timing_generator regression: fail");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_pixel_tick = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      fail_count     = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      hold_len       = 0;
      hold_seq       = 0;
      timing         = '{vstg_pkg::RST_H_VISIBLE, vstg_pkg::RST_H_FRONT,
                         vstg_pkg::RST_H_SYNC, vstg_pkg::RST_H_BACK,
                         vstg_pkg::RST_V_VISIBLE, vstg_pkg::RST_V_FRONT,
                         vstg_pkg::RST_V_SYNC, vstg_pkg::RST_V_BACK};
      pix_phase      = vstg_pkg::H_FRONT;
      pix_count      = '0;
      line_phase     = vstg_pkg::V_VISIBLE;
      line_count     = '0;
      vblank_now     = 1'b0;
      frame_count    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      recv_idle_pct = 84;
      test_directed_cases();
      test_small_frames(3);
      test_random_timing(1);

      send_idle_pct = 84;
      recv_idle_pct = 35;
      test_small_frames(2);
      test_random_timing(2);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_extreme_registers();
      test_backpressure();
      test_random_timing(2);
      test_small_frames(1);

      wait_drained();
      repeat (4) @(posedge clock);
      if (expected_px.size() != 0) begin
         fail_count++;
         $display("%0d expected pixels never came out", expected_px.size());
      end
      if (fail_count == 0)
         $display("video_sync_timing_generator regression: pass");
      else
         $display("video_sync_timing_generator regression: fail");
      $finish;
   end

endmodule
